// ===== rtl/snc_pkg.sv =====
// Shared types, character codes and lookup functions of the serial name and coordinate parser.
package snc_pkg;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_END  = 1'b1
  } op_t;

  typedef enum logic {
    KIND_COORD = 1'b0,
    KIND_NAME  = 1'b1
  } frame_kind_t;

  typedef enum logic [1:0] {
    MARK_NONE = 2'd0,
    MARK_X    = 2'd1,
    MARK_Y    = 2'd2
  } marker_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SHOW
  } ctrl_state_t;

  typedef struct packed {
    logic take_byte;
    logic end_frame;
    logic rd_en;
    logic advance;
  } snc_cmd_t;

  typedef struct packed {
    logic last;
  } snc_stat_t;

  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam logic [2:0] PREFIX_LEN = 3'd5;
  localparam logic [2:0] NAME_POS   = 3'd6;
  localparam int         DEFAULT_LEN = 7;

  function automatic logic [7:0] prefix_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0: c = 8'h4E;
      3'd1: c = 8'h41;
      3'd2: c = 8'h4D;
      3'd3: c = 8'h45;
      3'd4: c = 8'h3A;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] default_char(input logic [5:0] idx);
    logic [7:0] c;
    case (idx)
      6'd0: c = 8'h4E;
      6'd1: c = 8'h6F;
      6'd2: c = 8'h20;
      6'd3: c = 8'h46;
      6'd4: c = 8'h61;
      6'd5: c = 8'h63;
      6'd6: c = 8'h65;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/serial_name_coord_frame_parser.sv =====
// Top level of the serial name and coordinate frame parser.
// Each data beat is taken as it arrives while the input is not stalled. An
// end-of-frame beat starts a run of max(1, stored name length) result beats,
// during which the input is stalled; each result beat first reads the name
// memory into a register and is then shown, held while the result side stalls.
// A name frame rewrites the name memory as its bytes arrive, one byte per cycle.
module serial_name_coord_frame_parser #(
  parameter int MAX_DIGITS = 5,
  parameter int NAME_MAX   = 31
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_frame_kind,
  output logic [16:0] out_coord_x,
  output logic [16:0] out_coord_y,
  output logic [7:0]  out_name_char,
  output logic [4:0]  out_char_index,
  output logic        out_last
);

  snc_pkg::snc_cmd_t  cmd;
  snc_pkg::snc_stat_t stat;

  snc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_op     (in_op),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  snc_dp #(
    .MAX_DIGITS (MAX_DIGITS),
    .NAME_MAX   (NAME_MAX)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_data_byte   (in_data_byte),
    .out_frame_kind (out_frame_kind),
    .out_coord_x    (out_coord_x),
    .out_coord_y    (out_coord_y),
    .out_name_char  (out_name_char),
    .out_char_index (out_char_index),
    .out_last       (out_last)
  );

endmodule

// ===== rtl/snc_ctrl.sv =====
// Controller state machine that sequences byte intake and the result run.
module snc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_op,
  output logic                out_valid,
  input  logic                out_stall,
  input  snc_pkg::snc_stat_t  stat,
  output snc_pkg::snc_cmd_t   cmd
);

  snc_pkg::ctrl_state_t state_r;
  snc_pkg::ctrl_state_t state_nxt;
  logic                 in_fire;

  assign in_fire = in_valid && (state_r == snc_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= snc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      snc_pkg::ST_IDLE: begin
        if (in_fire && (in_op == snc_pkg::OP_END)) begin
          state_nxt = snc_pkg::ST_READ;
        end
      end
      snc_pkg::ST_READ: begin
        state_nxt = snc_pkg::ST_SHOW;
      end
      snc_pkg::ST_SHOW: begin
        if (!out_stall) begin
          state_nxt = stat.last ? snc_pkg::ST_IDLE : snc_pkg::ST_READ;
        end
      end
      default: begin
        state_nxt = snc_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      snc_pkg::ST_IDLE: begin
        in_stall      = 1'b0;
        cmd.take_byte = in_fire && (in_op == snc_pkg::OP_BYTE);
        cmd.end_frame = in_fire && (in_op == snc_pkg::OP_END);
      end
      snc_pkg::ST_READ: begin
        cmd.rd_en = 1'b1;
      end
      snc_pkg::ST_SHOW: begin
        out_valid   = 1'b1;
        cmd.advance = !out_stall && !stat.last;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.take_byte, cmd.end_frame, cmd.rd_en, cmd.advance}))
    else $error("more than one datapath command at once");

  a_read_then_show: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_en |=> out_valid)
    else $error("name read not followed by a result");

  a_end_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.end_frame |=> cmd.rd_en)
    else $error("frame end did not start a result run");

endmodule

// ===== rtl/snc_dp.sv =====
// Datapath holding frame parse state, coordinates, the name memory and result fields.
module snc_dp #(
  parameter int MAX_DIGITS = 5,
  parameter int NAME_MAX   = 31
) (
  input  logic                clk,
  input  logic                rst_n,
  input  snc_pkg::snc_cmd_t   cmd,
  output snc_pkg::snc_stat_t  stat,
  input  logic [7:0]          in_data_byte,
  output logic                out_frame_kind,
  output logic [16:0]         out_coord_x,
  output logic [16:0]         out_coord_y,
  output logic [7:0]          out_name_char,
  output logic [4:0]          out_char_index,
  output logic                out_last
);

  localparam int LEN_W   = $clog2(NAME_MAX + 1);
  localparam int IDX_W   = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1;
  localparam int DIG_W   = $clog2(MAX_DIGITS + 1);
  localparam int DEF_LEN = (NAME_MAX < snc_pkg::DEFAULT_LEN) ? NAME_MAX : snc_pkg::DEFAULT_LEN;

  logic [7:0]       name_mem [NAME_MAX];
  logic [7:0]       rd_data_r;

  logic [16:0]      x_r, x_nxt, y_r, y_nxt;
  logic [16:0]      x_acc_r, x_acc_nxt, y_acc_r, y_acc_nxt;
  logic [DIG_W-1:0] x_dig_r, x_dig_nxt, y_dig_r, y_dig_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [2:0]       bp_r, bp_nxt;
  logic             prefix_r, prefix_nxt;
  logic             stopped_r, stopped_nxt;
  logic             def_r, def_nxt;
  logic             kind_r, kind_nxt;
  snc_pkg::marker_t mark_r, mark_nxt;

  logic             mem_we;
  logic [IDX_W-1:0] mem_wa;
  logic             name_start;
  logic             name_byte;
  logic             is_digit;
  logic [3:0]       digit;
  logic [LEN_W-1:0] cur_len;
  logic             cur_stopped;
  logic             empty;

  assign is_digit    = (in_data_byte >= snc_pkg::CH_ZERO) && (in_data_byte <= snc_pkg::CH_NINE);
  assign digit       = 4'(in_data_byte - snc_pkg::CH_ZERO);
  assign name_start  = (bp_r == snc_pkg::PREFIX_LEN) && prefix_r;
  assign cur_len     = name_start ? '0 : len_r;
  assign cur_stopped = name_start ? 1'b0 : stopped_r;
  assign name_byte   = (bp_r >= snc_pkg::PREFIX_LEN) && prefix_r && !cur_stopped;
  assign mem_wa      = cur_len[IDX_W-1:0];
  assign empty       = (len_r == '0);

  always_comb begin
    x_nxt       = x_r;
    y_nxt       = y_r;
    x_acc_nxt   = x_acc_r;
    y_acc_nxt   = y_acc_r;
    x_dig_nxt   = x_dig_r;
    y_dig_nxt   = y_dig_r;
    len_nxt     = len_r;
    idx_nxt     = idx_r;
    bp_nxt      = bp_r;
    prefix_nxt  = prefix_r;
    stopped_nxt = stopped_r;
    def_nxt     = def_r;
    kind_nxt    = kind_r;
    mark_nxt    = mark_r;
    mem_we      = 1'b0;
    if (cmd.take_byte) begin
      if ((bp_r < snc_pkg::PREFIX_LEN) && (in_data_byte != snc_pkg::prefix_char(bp_r))) begin
        prefix_nxt = 1'b0;
      end
      if (name_start) begin
        def_nxt     = 1'b0;
        len_nxt     = '0;
        stopped_nxt = 1'b0;
      end
      if (name_byte) begin
        if ((in_data_byte == snc_pkg::CH_CR) || (in_data_byte == snc_pkg::CH_LF)) begin
          stopped_nxt = 1'b1;
        end else if (cur_len < LEN_W'(NAME_MAX)) begin
          mem_we  = 1'b1;
          len_nxt = cur_len + 1'b1;
        end
      end
      if (is_digit) begin
        if (mark_r == snc_pkg::MARK_X) begin
          if (x_dig_r < DIG_W'(MAX_DIGITS)) begin
            x_acc_nxt = 17'(x_acc_r * 17'd10) + 17'(digit);
            x_dig_nxt = x_dig_r + 1'b1;
          end
        end else if (y_dig_r < DIG_W'(MAX_DIGITS)) begin
          y_acc_nxt = 17'(y_acc_r * 17'd10) + 17'(digit);
          y_dig_nxt = y_dig_r + 1'b1;
        end
      end else if (in_data_byte == snc_pkg::CH_HASH) begin
        mark_nxt = snc_pkg::MARK_X;
      end else if (in_data_byte == snc_pkg::CH_DOLLAR) begin
        mark_nxt = snc_pkg::MARK_Y;
      end
      if (bp_r < snc_pkg::NAME_POS) begin
        bp_nxt = bp_r + 3'd1;
      end
    end else if (cmd.end_frame) begin
      kind_nxt = ((bp_r == snc_pkg::NAME_POS) && prefix_r) ? snc_pkg::KIND_NAME
                                                          : snc_pkg::KIND_COORD;
      if (!((bp_r == snc_pkg::NAME_POS) && prefix_r)) begin
        x_nxt = x_acc_r;
        y_nxt = y_acc_r;
      end
      bp_nxt      = '0;
      prefix_nxt  = 1'b1;
      stopped_nxt = 1'b0;
      mark_nxt    = snc_pkg::MARK_NONE;
      x_acc_nxt   = '0;
      y_acc_nxt   = '0;
      x_dig_nxt   = '0;
      y_dig_nxt   = '0;
      idx_nxt     = '0;
    end else if (cmd.advance) begin
      idx_nxt = idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r       <= '0;
      y_r       <= '0;
      x_acc_r   <= '0;
      y_acc_r   <= '0;
      x_dig_r   <= '0;
      y_dig_r   <= '0;
      len_r     <= LEN_W'(DEF_LEN);
      idx_r     <= '0;
      bp_r      <= '0;
      prefix_r  <= 1'b1;
      stopped_r <= 1'b0;
      def_r     <= 1'b1;
      kind_r    <= snc_pkg::KIND_COORD;
      mark_r    <= snc_pkg::MARK_NONE;
    end else begin
      x_r       <= x_nxt;
      y_r       <= y_nxt;
      x_acc_r   <= x_acc_nxt;
      y_acc_r   <= y_acc_nxt;
      x_dig_r   <= x_dig_nxt;
      y_dig_r   <= y_dig_nxt;
      len_r     <= len_nxt;
      idx_r     <= idx_nxt;
      bp_r      <= bp_nxt;
      prefix_r  <= prefix_nxt;
      stopped_r <= stopped_nxt;
      def_r     <= def_nxt;
      kind_r    <= kind_nxt;
      mark_r    <= mark_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      name_mem[mem_wa] <= in_data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data_r <= name_mem[idx_r];
    end
  end

  assign stat.last      = empty || ((LEN_W'(idx_r) + 1'b1) == len_r);
  assign out_frame_kind = kind_r;
  assign out_coord_x    = x_r;
  assign out_coord_y    = y_r;
  assign out_char_index = 5'(idx_r);
  assign out_last       = stat.last;
  assign out_name_char  = empty ? 8'h00 : (def_r ? snc_pkg::default_char(6'(idx_r)) : rd_data_r);

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_W'(NAME_MAX))
    else $error("name length beyond capacity");

  a_digit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (x_dig_r <= DIG_W'(MAX_DIGITS)) && (y_dig_r <= DIG_W'(MAX_DIGITS)))
    else $error("digit count beyond limit");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.end_frame |=> (bp_r == 3'd0) && (x_acc_r == 17'd0) && (y_acc_r == 17'd0))
    else $error("frame state not cleared at frame end");

  a_name_keeps_coords: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.end_frame && (bp_r == snc_pkg::NAME_POS) && prefix_r) |=> $stable(x_r) && $stable(y_r))
    else $error("name frame changed stored coordinates");

endmodule
